// ===== rtl/core/tcaf_pkg.sv =====
// Package for the touch contact activation filter.
// Holds command codes, report kinds, register indexes, reset values and the result record.
// No dependencies.
package tcaf_pkg;

  localparam int unsigned FIELD_W   = 16;
  localparam int unsigned FRAMES_W  = 7;
  localparam int unsigned LEVEL_W   = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned BYTE_W    = 8;

  typedef enum logic [3:0] {
    CMD_GROUP_START   = 4'd0,
    CMD_TIP           = 4'd1,
    CMD_CONFIDENCE    = 4'd2,
    CMD_X             = 4'd3,
    CMD_Y             = 4'd4,
    CMD_ID            = 4'd5,
    CMD_WIDTH         = 4'd6,
    CMD_HEIGHT        = 4'd7,
    CMD_FOOTER        = 4'd8,
    CMD_CONTACT_COUNT = 4'd9
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_SINGLE  = 2'd0,
    KIND_CONTACT = 2'd1,
    KIND_BUTTON  = 2'd2
  } kind_e;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_HEIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACT_WIDTH     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACT_HEIGHT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ACT_FRAMES    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DEACT_FRAMES  = 3'd5;

  localparam logic [FIELD_W-1:0]  MIN_WIDTH_RST    = 16'd0;
  localparam logic [FIELD_W-1:0]  MIN_HEIGHT_RST   = 16'd0;
  localparam logic [FIELD_W-1:0]  ACT_WIDTH_RST    = 16'd64;
  localparam logic [FIELD_W-1:0]  ACT_HEIGHT_RST   = 16'd32;
  localparam logic [FRAMES_W-1:0] ACT_FRAMES_RST   = 7'd1;
  localparam logic [FRAMES_W-1:0] DEACT_FRAMES_RST = 7'd4;

  typedef struct packed {
    kind_e              kind;
    logic               touch;
    logic               primary;
    logic [FIELD_W-1:0] pos_x;
    logic [FIELD_W-1:0] pos_y;
    logic               orient;
    logic [FIELD_W-1:0] major;
    logic [FIELD_W-1:0] minor;
  } res_t;

endpackage

// ===== rtl/core/touch_contact_activation_filter_unit.sv =====
// Touch contact activation filter, top level.
// Depends on tcaf_pkg.
//
// Usage: report fields enter one per transfer on the input channel (command_i,
// field_value_i, qualified by in_valid_i / in_stall_o). Contact fields are
// latched; each contact closes with FOOTER_WORDS footer bytes, which filter it
// by pen activity, finger presence, size and confidence and may produce a
// contact result. The contact count ends a group and may produce a frame
// touch-button result; a height field outside a group produces a single-touch
// position. Results leave on the output channel (out_valid_o / out_stall_i).
// A result is registered in the output register before it leaves.
// Throughput: one field per cycle while in_stall_o is low; state updates in the
// same edge that takes the field, so consecutive fields see each other with no bubbles.
// A one-entry skid register behind the output register absorbs the result that
// arrives while the receiver stalls; in_stall_o rises only while the skid entry
// is full, and it is a register output.
// Reset clears all contact state, loads the register defaults and sets the
// activation level to the default activate_frames. Configuration writes
// (cfg_we_i, cfg_index_i, cfg_data_i) take effect at the next edge.
module touch_contact_activation_filter_unit #(
  parameter int unsigned COORD_BITS   = 16,
  parameter int unsigned FOOTER_WORDS = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [tcaf_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [tcaf_pkg::FIELD_W-1:0]      cfg_data_i,
  // report fields in
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [3:0]                        command_i,
  input  logic [tcaf_pkg::FIELD_W-1:0]      field_value_i,
  // results out
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [1:0]                        report_kind_o,
  output logic                              touch_on_o,
  output logic                              primary_contact_o,
  output logic [tcaf_pkg::FIELD_W-1:0]      pos_x_o,
  output logic [tcaf_pkg::FIELD_W-1:0]      pos_y_o,
  output logic                              orientation_o,
  output logic [tcaf_pkg::FIELD_W-1:0]      major_axis_o,
  output logic [tcaf_pkg::FIELD_W-1:0]      minor_axis_o
);
  import tcaf_pkg::*;

  localparam int unsigned CNT_W = $clog2(FOOTER_WORDS + 1);
  localparam int unsigned IDX_W = $clog2(FOOTER_WORDS);

  // configuration registers
  logic [FIELD_W-1:0]  min_w_q, min_h_q, act_w_q, act_h_q;
  logic [FRAMES_W-1:0] act_frames_q, deact_frames_q;

  // contact state
  logic [COORD_BITS-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [FIELD_W-1:0]    cur_w_q, cur_w_d, cur_h_q, cur_h_d, ident_q, ident_d;
  logic                  tip_q, tip_d, conf_q, conf_d, first_q, first_d;
  logic                  in_group_q, in_group_d;
  logic [BYTE_W-1:0]     footer_q [FOOTER_WORDS];
  logic [BYTE_W-1:0]     footer_d [FOOTER_WORDS];
  logic [CNT_W-1:0]      foot_cnt_q, foot_cnt_d;
  logic signed [LEVEL_W-1:0] level_q, level_d;

  // output register and skid entry
  logic out_vld_q, skid_vld_q;
  res_t out_q, skid_q;

  logic in_acc, out_acc, res_vld;
  res_t res;

  logic                      foot_room, foot_done, conf_eff, big_contact, emit_ok;
  logic [IDX_W-1:0]          foot_idx;
  logic signed [LEVEL_W-1:0] act_lvl, neg_deact, pen_lvl;
  logic [FIELD_W-1:0]        pos_x_ext, pos_y_ext;

  assign in_stall_o = skid_vld_q;
  assign in_acc     = in_valid_i && !skid_vld_q;
  assign out_acc    = out_vld_q && !out_stall_i;

  assign act_lvl   = $signed({1'b0, act_frames_q});
  assign pen_lvl   = ~$signed({1'b0, deact_frames_q});       // -deact - 1
  assign neg_deact = pen_lvl + 8'sd1;                         // -deact
  assign pos_x_ext = FIELD_W'(cur_x_q);
  assign pos_y_ext = FIELD_W'(cur_y_q);
  assign foot_idx  = foot_cnt_q[IDX_W-1:0];
  assign foot_room = foot_cnt_q < CNT_W'(FOOTER_WORDS);
  assign big_contact = (cur_w_q >= act_w_q) && (cur_h_q >= act_h_q);

  // field decode: next state and the result, if any
  always_comb begin
    cur_x_d    = cur_x_q;
    cur_y_d    = cur_y_q;
    cur_w_d    = cur_w_q;
    cur_h_d    = cur_h_q;
    ident_d    = ident_q;
    tip_d      = tip_q;
    conf_d     = conf_q;
    first_d    = first_q;
    in_group_d = in_group_q;
    foot_cnt_d = foot_cnt_q;
    level_d    = level_q;
    footer_d   = footer_q;
    foot_done  = 1'b0;
    conf_eff   = 1'b0;
    emit_ok    = 1'b0;
    res_vld    = 1'b0;
    res        = '0;

    if (in_acc) begin
      case (command_i)
        CMD_GROUP_START: begin
          in_group_d = 1'b1;
          first_d    = 1'b0;
        end
        CMD_TIP:        tip_d   = field_value_i != '0;
        CMD_CONFIDENCE: conf_d  = field_value_i != '0;
        CMD_X: begin
          cur_x_d    = field_value_i[COORD_BITS-1:0];
          foot_cnt_d = '0;
        end
        CMD_Y:     cur_y_d = field_value_i[COORD_BITS-1:0];
        CMD_ID:    ident_d = field_value_i;
        CMD_WIDTH: cur_w_d = field_value_i;
        CMD_HEIGHT: begin
          cur_h_d = field_value_i;
          if (!in_group_q) begin
            res_vld     = 1'b1;
            res.kind    = KIND_SINGLE;
            res.touch   = tip_q;
            res.pos_x   = pos_x_ext;
            res.pos_y   = pos_y_ext;
          end
        end
        CMD_FOOTER: begin
          if (foot_room) begin
            footer_d[foot_idx] = field_value_i[BYTE_W-1:0];
            foot_cnt_d         = foot_cnt_q + 1'b1;
            foot_done          = foot_cnt_q == CNT_W'(FOOTER_WORDS - 1);
          end
          if (foot_done) begin
            if (footer_d[2] != '0) begin
              // pen active: hold touch off past the deactivate slack
              level_d = pen_lvl;
              conf_d  = 1'b0;
            end else if (footer_d[0] != '0) begin
              conf_eff = conf_q && !((cur_w_q < min_w_q) || (cur_h_q < min_h_q));
              conf_d   = conf_eff;
              emit_ok  = 1'b1;
              if (level_q > 8'sd0) begin
                if (big_contact && ident_q != '0) begin
                  level_d = '0;
                end else begin
                  emit_ok = 1'b0;
                  if (big_contact) level_d = 8'sd1;
                end
              end
              if (emit_ok && conf_eff) begin
                if (ident_q == '0) first_d = 1'b1;
                res_vld     = 1'b1;
                res.kind    = KIND_CONTACT;
                res.primary = ident_q == '0;
                res.pos_x   = pos_x_ext;
                res.pos_y   = pos_y_ext;
                res.orient  = cur_w_q > cur_h_q;
                res.major   = (cur_w_q > cur_h_q) ? cur_w_q : cur_h_q;
                res.minor   = (cur_w_q > cur_h_q) ? cur_h_q : cur_w_q;
              end
            end
          end
        end
        CMD_CONTACT_COUNT: begin
          if (in_group_q) begin
            in_group_d = 1'b0;
            res.kind   = KIND_BUTTON;
            if (level_q > 8'sd0) begin
              if (field_value_i == '0) begin
                level_d = act_lvl;
              end else if (FIELD_W'(level_q[LEVEL_W-2:0]) > field_value_i) begin
                level_d = level_q - $signed({1'b0, field_value_i[LEVEL_W-2:0]});
              end else begin
                level_d = '0;
              end
            end else if (field_value_i != '0 && level_q >= neg_deact) begin
              level_d   = '0;
              res_vld   = 1'b1;
              res.touch = first_q;
            end else if (level_q <= neg_deact) begin
              level_d   = act_lvl;
              res_vld   = 1'b1;
              res.touch = first_q && (act_frames_q == '0);
            end else begin
              level_d = level_q - 8'sd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_w_q        <= MIN_WIDTH_RST;
      min_h_q        <= MIN_HEIGHT_RST;
      act_w_q        <= ACT_WIDTH_RST;
      act_h_q        <= ACT_HEIGHT_RST;
      act_frames_q   <= ACT_FRAMES_RST;
      deact_frames_q <= DEACT_FRAMES_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MIN_WIDTH:    min_w_q        <= cfg_data_i;
        CFG_MIN_HEIGHT:   min_h_q        <= cfg_data_i;
        CFG_ACT_WIDTH:    act_w_q        <= cfg_data_i;
        CFG_ACT_HEIGHT:   act_h_q        <= cfg_data_i;
        CFG_ACT_FRAMES:   act_frames_q   <= cfg_data_i[FRAMES_W-1:0];
        CFG_DEACT_FRAMES: deact_frames_q <= cfg_data_i[FRAMES_W-1:0];
        default: ;
      endcase
    end
  end

  // contact and activation state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q    <= '0;
      cur_y_q    <= '0;
      cur_w_q    <= '0;
      cur_h_q    <= '0;
      ident_q    <= '0;
      tip_q      <= 1'b0;
      conf_q     <= 1'b0;
      first_q    <= 1'b0;
      in_group_q <= 1'b0;
      foot_cnt_q <= '0;
      level_q    <= $signed({1'b0, ACT_FRAMES_RST});
      for (int i = 0; i < FOOTER_WORDS; i++) footer_q[i] <= '0;
    end else begin
      cur_x_q    <= cur_x_d;
      cur_y_q    <= cur_y_d;
      cur_w_q    <= cur_w_d;
      cur_h_q    <= cur_h_d;
      ident_q    <= ident_d;
      tip_q      <= tip_d;
      conf_q     <= conf_d;
      first_q    <= first_d;
      in_group_q <= in_group_d;
      foot_cnt_q <= foot_cnt_d;
      level_q    <= level_d;
      footer_q   <= footer_d;
    end
  end

  // output register with skid: the skid entry fills only while the output is stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (!out_vld_q || out_acc) begin
      out_vld_q  <= skid_vld_q || res_vld;
      skid_vld_q <= 1'b0;
    end else if (res_vld) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || out_acc) begin
      out_q <= skid_vld_q ? skid_q : res;
    end else if (res_vld) begin
      skid_q <= res;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign report_kind_o     = out_q.kind;
  assign touch_on_o        = out_q.touch;
  assign primary_contact_o = out_q.primary;
  assign pos_x_o           = out_q.pos_x;
  assign pos_y_o           = out_q.pos_y;
  assign orientation_o     = out_q.orient;
  assign major_axis_o      = out_q.major;
  assign minor_axis_o      = out_q.minor;

  // the skid entry is never full while the output register is empty
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry valid with empty output register");

  // the skid entry fills only when a held result was stalled
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(out_vld_q && out_stall_i))
    else $error("skid entry filled without a stalled output");

  // the footer count never runs past the footer length
  a_foot_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    foot_cnt_q <= CNT_W'(FOOTER_WORDS))
    else $error("footer count overran");

  // a group start always opens a group
  a_group_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && command_i == CMD_GROUP_START) |=> in_group_q)
    else $error("group start did not open a group");

endmodule
